/* src/three_voice_dds_sine_mixer_defines.svh */
// Assertion macros shared by the checkers of the three-voice DDS sine mixer.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef THREE_VOICE_DDS_SINE_MIXER_DEFINES_SVH
`define THREE_VOICE_DDS_SINE_MIXER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TVDDS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TVDDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tvdds_pkg.sv */
// Shared constants, types and the sine table generator of the DDS sine mixer.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package tvdds_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 12;

    localparam int POT_W    = 12;
    localparam int OUT_W    = 12;
    localparam int SWEEP_W  = 16;
    localparam int DELTA_W  = 12;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    localparam int                   CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP = 2'd1;
    localparam logic [SWEEP_W-1:0]   SWEEP_STEP_RST = 16'd573;

    // Pot rescale: lo + floor(pot * (hi - lo) / 4095), then times the gain.
    localparam int SPAN_W      = 13;
    localparam int RESC_W      = 13;
    localparam int PROD_W      = POT_W + SPAN_W;
    localparam int GAIN_W      = 18;
    localparam int TUNE_W      = GAIN_W + RESC_W;
    localparam int POT_FULL    = 4095;
    localparam int FREQ_LO     = 10;
    localparam int FREQ_HI_AB  = 5000;
    localparam int FREQ_HI_C   = 2000;
    localparam logic [SPAN_W-1:0] SPAN_AB = SPAN_W'(FREQ_HI_AB - FREQ_LO);
    localparam logic [SPAN_W-1:0] SPAN_C  = SPAN_W'(FREQ_HI_C - FREQ_LO);
    localparam logic [GAIN_W-1:0] TUNE_GAIN = 18'd257374;

    // Exact floor division by 4095 for products below 2^PROD_W.
    localparam int                  RECIP_SHIFT = PROD_W + 12;
    localparam int                  RECIP_W     = 26;
    localparam logic [RECIP_W-1:0]  RECIP_POT   =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(POT_FULL) - 64'd1) / 64'(POT_FULL));

    localparam logic [63:0] TUNING_A_RST = 64'd15737418;
    localparam logic [63:0] TUNING_B_RST = 64'd25737418;
    localparam logic [63:0] TUNING_C_RST = 64'd35737418;

    // Pipeline: product, quotient, tuning word, phase, table, mix/output.
    localparam int NSTAGE    = 6;
    localparam int LANE_STGS = 5;

    typedef struct packed {
        logic [LANE_STGS-1:0] adv;     // stage loads this cycle
        logic                 commit;  // a valid request reaches the phase stage
        logic                 sweep;   // sweep mode
        logic [DELTA_W-1:0]   delta;   // sweep step already shifted
    } lane_ctl_t;

    localparam logic [63:0] C1_Q30 = 64'd1686629713;
    localparam logic [63:0] C3_Q30 = 64'd693598668;
    localparam logic [63:0] C5_Q30 = 64'd85569306;
    localparam logic [63:0] C7_Q30 = 64'd5026995;
    localparam logic [63:0] C9_Q30 = 64'd172272;

    // Offset sine table entry, evaluated at elaboration only.
    function automatic logic [31:0] sine_entry(input int unsigned idx, input int abits,
                                               input int sbits);
        logic [63:0] quarter;
        logic [63:0] mid;
        logic [63:0] amp;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] mag;
        logic [1:0]  quad;
        int          qbits;
        qbits   = abits - 2;
        quarter = 64'd1 << qbits;
        mid     = 64'd1 << (sbits - 1);
        amp     = mid - 64'd1;
        quad    = 2'(idx >> qbits);
        r       = 64'(idx) & (quarter - 64'd1);
        q       = quad[0] ? (quarter - r) : r;
        t       = q << (30 - qbits);
        t2      = (t * t) >> 30;
        p       = C9_Q30;
        p       = C7_Q30 - ((t2 * p) >> 30);
        p       = C5_Q30 - ((t2 * p) >> 30);
        p       = C3_Q30 - ((t2 * p) >> 30);
        p       = C1_Q30 - ((t2 * p) >> 30);
        s       = (t * p) >> 30;
        mag     = (amp * s + (64'd1 << 29)) >> 30;
        if (mag > amp) begin
            mag = amp;
        end
        return quad[1] ? 32'(mid - mag) : 32'(mid + mag);
    endfunction

endpackage

/* src/tvdds_lane.sv */
// One voice lane: pot rescale to a tuning word, phase accumulator and sine table.
// Depends on tvdds_pkg for widths, constants, the control struct and the table.
`timescale 1ns / 1ps

module tvdds_lane #(
    parameter int          PHASE_BITS      = tvdds_pkg::PHASE_BITS_DEF,
    parameter int          TABLE_ADDR_BITS = tvdds_pkg::TABLE_ADDR_BITS_DEF,
    parameter int          SAMPLE_BITS     = tvdds_pkg::SAMPLE_BITS_DEF,
    parameter logic [tvdds_pkg::SPAN_W-1:0] SPAN = tvdds_pkg::SPAN_AB,
    parameter logic [63:0] TUNING_RST      = tvdds_pkg::TUNING_A_RST,
    parameter bit          SWEEP_DOWN      = 1'b0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tvdds_pkg::lane_ctl_t          ctl,
    input  logic [tvdds_pkg::POT_W-1:0]   pot,
    output logic [SAMPLE_BITS-1:0]        sine
);

    localparam int TABLE_DEPTH = 2 ** TABLE_ADDR_BITS;
    localparam int QPROD_W     = tvdds_pkg::PROD_W + tvdds_pkg::RECIP_W;

    logic [tvdds_pkg::PROD_W-1:0] prod_reg;
    logic [tvdds_pkg::RESC_W-1:0] quot_reg;
    logic [PHASE_BITS-1:0]        word_reg;
    logic [PHASE_BITS-1:0]        phase_reg;
    logic [PHASE_BITS-1:0]        phase_next;
    logic [PHASE_BITS-1:0]        tuning_reg;
    logic [PHASE_BITS-1:0]        tuning_next;
    logic [TABLE_ADDR_BITS-1:0]   addr_reg;
    logic [SAMPLE_BITS-1:0]       sine_reg;
    logic [QPROD_W-1:0]           qprod;
    logic [tvdds_pkg::RESC_W-1:0] resc;
    logic [tvdds_pkg::TUNE_W-1:0] tune_full;
    logic [SAMPLE_BITS-1:0]       rom [TABLE_DEPTH];

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_rom
        assign rom[gi] = SAMPLE_BITS'(tvdds_pkg::sine_entry(gi, TABLE_ADDR_BITS, SAMPLE_BITS));
    end

    assign qprod     = QPROD_W'(prod_reg) * QPROD_W'(tvdds_pkg::RECIP_POT);
    assign resc      = quot_reg + tvdds_pkg::RESC_W'(tvdds_pkg::FREQ_LO);
    assign tune_full = tvdds_pkg::TUNE_W'(tvdds_pkg::TUNE_GAIN) * tvdds_pkg::TUNE_W'(resc);
    assign phase_next = phase_reg + tuning_reg;

    always_comb begin
        if (ctl.sweep) begin
            if (SWEEP_DOWN) begin
                tuning_next = tuning_reg - PHASE_BITS'(ctl.delta);
            end else begin
                tuning_next = tuning_reg + PHASE_BITS'(ctl.delta);
            end
        end else begin
            tuning_next = word_reg;
        end
    end

    // Datapath stages; they load whenever the stage moves on.
    always_ff @(posedge aclk) begin
        if (ctl.adv[0]) begin
            prod_reg <= tvdds_pkg::PROD_W'(pot) * tvdds_pkg::PROD_W'(SPAN);
        end
        if (ctl.adv[1]) begin
            quot_reg <= tvdds_pkg::RESC_W'(qprod >> tvdds_pkg::RECIP_SHIFT);
        end
        if (ctl.adv[2]) begin
            word_reg <= PHASE_BITS'(tune_full);
        end
        if (ctl.adv[3]) begin
            addr_reg <= phase_next[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        end
        if (ctl.adv[4]) begin
            sine_reg <= rom[addr_reg];
        end
    end

    // The accumulator moves only for real requests; in pot mode the word carried by a
    // request becomes the tuning for the one after it, in sweep mode the tuning moves by delta.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            tuning_reg <= PHASE_BITS'(TUNING_RST);
        end else if (ctl.commit) begin
            phase_reg  <= phase_next;
            tuning_reg <= tuning_next;
        end
    end

    assign sine = sine_reg;

endmodule

/* src/tvdds_merge.sv */
// Merging stage: sums the three lane sines and divides by three into the output.
// Depends on tvdds_pkg for the output width.
`timescale 1ns / 1ps

module tvdds_merge #(
    parameter int SAMPLE_BITS = tvdds_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        adv,
    input  logic [SAMPLE_BITS-1:0]      sine_a,
    input  logic [SAMPLE_BITS-1:0]      sine_b,
    input  logic [SAMPLE_BITS-1:0]      sine_c,
    output logic [tvdds_pkg::OUT_W-1:0] sample
);

    localparam int SUM_W   = SAMPLE_BITS + 2;
    localparam int DIV_SH  = SAMPLE_BITS + 4;
    localparam int RECIP_W = SAMPLE_BITS + 3;
    localparam int MUL_W   = SUM_W + RECIP_W;
    // Rounded-up reciprocal of three; exact for every sum below 2^SUM_W.
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((64'd1 << DIV_SH) + 64'd2) / 64'd3);

    logic [SUM_W-1:0]             sum;
    logic [MUL_W-1:0]             mul;
    logic [SAMPLE_BITS-1:0]       quot;
    logic [tvdds_pkg::OUT_W-1:0]  sample_reg;

    assign sum  = SUM_W'(sine_a) + SUM_W'(sine_b) + SUM_W'(sine_c);
    assign mul  = MUL_W'(sum) * MUL_W'(RECIP3);
    assign quot = SAMPLE_BITS'(mul >> DIV_SH);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sample_reg <= tvdds_pkg::OUT_W'(quot);
        end
    end

    assign sample = sample_reg;

endmodule

/* src/three_voice_dds_sine_mixer.sv */
// Top level of the three-voice DDS sine mixer: stage control, configuration,
// three voice lanes and the merging stage. Depends on tvdds_pkg, tvdds_lane, tvdds_merge.
`timescale 1ns / 1ps

// Takes one request of three pot readings per clock while s_tready is high and gives
// one 12-bit DAC sample per request. Each request passes through the six-stage
// pipeline: pot times span, reciprocal multiply for the division by 4095, tuning
// gain multiply, phase accumulate, sine table, then mix and divide by three. Each
// voice's phase advances by the tuning word left by the previous request; in pot
// mode that word comes from the previous request's pot, in sweep mode it moves by
// sweep_step >> 4 (voices a and c up, b down). The pipeline closes up its bubbles,
// so s_tready drops only while the output register holds a sample that is not taken.
// Configuration writes are always ready and take effect at once; write them only while
// the block is empty.
module three_voice_dds_sine_mixer #(
    parameter int PHASE_BITS      = tvdds_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = tvdds_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = tvdds_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tvdds_pkg::S_DATA_W-1:0]    s_tdata,   // pot_a, pot_b, pot_c, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tvdds_pkg::M_DATA_W-1:0]    m_tdata,   // sample, zero pad
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tvdds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tvdds_pkg::SWEEP_W-1:0]     cfg_data
);

    localparam int NS = tvdds_pkg::NSTAGE;
    localparam int PW = tvdds_pkg::POT_W;

    logic [NS-1:0]                  valid_reg;
    logic [NS-1:0]                  valid_next;
    logic [NS-1:0]                  adv;
    logic                           mode_reg;
    logic [tvdds_pkg::SWEEP_W-1:0]  sweep_step_reg;
    tvdds_pkg::lane_ctl_t           ctl;
    logic [SAMPLE_BITS-1:0]         sine_a;
    logic [SAMPLE_BITS-1:0]         sine_b;
    logic [SAMPLE_BITS-1:0]         sine_c;
    logic [tvdds_pkg::OUT_W-1:0]    sample;

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        adv[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = valid_reg;
        if (adv[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NS; i++) begin
            if (adv[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            sweep_step_reg <= tvdds_pkg::SWEEP_STEP_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tvdds_pkg::CFG_MODE:       mode_reg       <= cfg_data[0];
                tvdds_pkg::CFG_SWEEP_STEP: sweep_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ctl.adv    = adv[tvdds_pkg::LANE_STGS-1:0];
    assign ctl.commit = adv[3] && valid_reg[2];
    assign ctl.sweep  = mode_reg;
    assign ctl.delta  = sweep_step_reg[tvdds_pkg::SWEEP_W-1 -: tvdds_pkg::DELTA_W];

    tvdds_lane #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SPAN            (tvdds_pkg::SPAN_AB),
        .TUNING_RST      (tvdds_pkg::TUNING_A_RST),
        .SWEEP_DOWN      (1'b0)
    ) u_lane_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .pot     (s_tdata[PW-1:0]),
        .sine    (sine_a)
    );

    tvdds_lane #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SPAN            (tvdds_pkg::SPAN_AB),
        .TUNING_RST      (tvdds_pkg::TUNING_B_RST),
        .SWEEP_DOWN      (1'b1)
    ) u_lane_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .pot     (s_tdata[2*PW-1:PW]),
        .sine    (sine_b)
    );

    tvdds_lane #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SPAN            (tvdds_pkg::SPAN_C),
        .TUNING_RST      (tvdds_pkg::TUNING_C_RST),
        .SWEEP_DOWN      (1'b0)
    ) u_lane_c (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .pot     (s_tdata[3*PW-1:2*PW]),
        .sine    (sine_c)
    );

    tvdds_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk   (aclk),
        .adv    (adv[NS-1]),
        .sine_a (sine_a),
        .sine_b (sine_b),
        .sine_c (sine_c),
        .sample (sample)
    );

    assign s_tready  = adv[0];
    assign m_tvalid  = valid_reg[NS-1];
    assign m_tdata   = tvdds_pkg::M_DATA_W'(sample);
    assign cfg_ready = 1'b1;

endmodule

/* src/tvdds_checker.sv */
// Port-level checks of the three-voice DDS sine mixer, bound to its top level.
// Depends on tvdds_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "three_voice_dds_sine_mixer_defines.svh"

module tvdds_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tvdds_pkg::M_DATA_W-1:0]  m_tdata
);

    // A held sample stays on the bus unchanged.
    `TVDDS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")

    // The output only drops after a sample has been taken.
    `TVDDS_ASSERT_NOW(a_out_drop, aclk, aresetn, $fell(m_tvalid), $past(m_tready), "output dropped without being taken")

    // The input is refused only when the output holds a sample that is not taken.
    `TVDDS_ASSERT_NOW(a_in_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled with room in the pipeline")

    // The padding above the 12-bit sample is always zero.
    `TVDDS_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[tvdds_pkg::M_DATA_W-1:tvdds_pkg::OUT_W] == '0, "sample padding not zero")

endmodule

bind three_voice_dds_sine_mixer tvdds_checker u_tvdds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/three_voice_dds_sine_mixer_tb.sv */
// Self-checking testbench for the three-voice DDS sine mixer: pot requests are streamed
// in, every DAC sample is compared against a cycle-free model of the phase accumulators.
// Depends on tvdds_pkg and three_voice_dds_sine_mixer.
`timescale 1ns / 1ps

module three_voice_dds_sine_mixer_tb;

    localparam logic [tvdds_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [tvdds_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    localparam bit [63:0] WAVE_C1   = 64'd1686629713;
    localparam bit [63:0] WAVE_C3   = 64'd693598668;
    localparam bit [63:0] WAVE_C5   = 64'd85569306;
    localparam bit [63:0] WAVE_C7   = 64'd5026995;
    localparam bit [63:0] WAVE_C9   = 64'd172272;
    localparam bit [63:0] WAVE_MID  = 64'd2048;
    localparam bit [63:0] WAVE_AMP  = 64'd2047;

    localparam bit [63:0] FREQ_BASE   = 64'd10;
    localparam bit [63:0] FREQ_SPAN_AB = 64'd4990;
    localparam bit [63:0] FREQ_SPAN_C  = 64'd1990;
    localparam bit [63:0] POT_TOP     = 64'd4095;
    localparam bit [63:0] TUNE_MULT   = 64'd257374;

    localparam int HOLD_AT_RESULT = 1000;
    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 20;

    // pot_a occupies the low bits, matching the tdata layout.
    typedef struct packed {
        bit [11:0] pot_c;
        bit [11:0] pot_b;
        bit [11:0] pot_a;
    } pot_set_t;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [tvdds_pkg::S_DATA_W-1:0]       s_tdata   = '0;
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [tvdds_pkg::M_DATA_W-1:0]       m_tdata;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [tvdds_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [tvdds_pkg::SWEEP_W-1:0]        cfg_data  = '0;

    // Model state: accumulators, tuning words and register copies.
    bit [11:0] wave_table [1024];
    bit [31:0] acc_phase [3];
    bit [31:0] tune_word [3];
    bit        sweep_mode;
    bit [15:0] sweep_step;

    pot_set_t  pending_pots [$];
    bit [11:0] sample_expect_q [$];
    int        items_issued   = 0;
    int        items_accepted = 0;
    int        results_seen   = 0;
    int        mismatch_count = 0;
    int        send_idle_pct  = 32;
    int        recv_idle_pct  = 48;
    int        hold_left      = 0;

    three_voice_dds_sine_mixer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Offset sine level: quarter-wave Taylor series in Q30, mirrored into four quadrants.
    function automatic bit [11:0] sine_level(bit [9:0] idx);
        bit [63:0] horner [5];
        bit [63:0] r;
        bit [63:0] t;
        bit [63:0] t2;
        bit [63:0] p;
        bit [63:0] mag;
        horner = '{WAVE_C9, WAVE_C7, WAVE_C5, WAVE_C3, WAVE_C1};
        r = 64'(idx[7:0]);
        if (idx[8]) begin
            r = 64'd256 - r;
        end
        t  = r << 22;
        t2 = (t * t) >> 30;
        p  = horner[0];
        for (int k = 1; k < 5; k++) begin
            p = horner[k] - ((t2 * p) >> 30);
        end
        mag = (WAVE_AMP * ((t * p) >> 30) + (64'd1 << 29)) >> 30;
        if (mag > WAVE_AMP) begin
            mag = WAVE_AMP;
        end
        return idx[9] ? 12'(WAVE_MID - mag) : 12'(WAVE_MID + mag);
    endfunction

    function automatic bit [31:0] pot_tuning(bit [11:0] pot, bit [63:0] span);
        return 32'((FREQ_BASE + (64'(pot) * span) / POT_TOP) * TUNE_MULT);
    endfunction

    // Advances the three voices by one tick and returns the mixed sample.
    function automatic bit [11:0] dds_next_sample(pot_set_t pots);
        bit [11:0]   pot_v [3];
        int unsigned level_sum;
        bit [31:0]   delta;
        pot_v     = '{pots.pot_a, pots.pot_b, pots.pot_c};
        level_sum = 0;
        for (int v = 0; v < 3; v++) begin
            acc_phase[v] = acc_phase[v] + tune_word[v];
            level_sum    = level_sum + wave_table[acc_phase[v][31:22]];
        end
        if (sweep_mode) begin
            delta        = 32'(sweep_step >> 4);
            tune_word[0] = tune_word[0] + delta;
            tune_word[1] = tune_word[1] - delta;
            tune_word[2] = tune_word[2] + delta;
        end else begin
            for (int v = 0; v < 3; v++) begin
                tune_word[v] = pot_tuning(pot_v[v], (v == 2) ? FREQ_SPAN_C : FREQ_SPAN_AB);
            end
        end
        return 12'(level_sum / 3);
    endfunction

    function automatic bit [11:0] rand_pot();
        case ($urandom_range(7))
            0: return 12'd0;
            1: return 12'd4095;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    task automatic queue_pots(bit [11:0] a, bit [11:0] b, bit [11:0] c);
        pot_set_t item;
        item.pot_a = a;
        item.pot_b = b;
        item.pot_c = c;
        pending_pots.push_back(item);
        items_issued++;
    endtask

    task automatic queue_random(int n);
        repeat (n) queue_pots(rand_pot(), rand_pot(), rand_pot());
    endtask

    task automatic wait_drained();
        while (items_accepted != items_issued || sample_expect_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [tvdds_pkg::CFG_IDX_W-1:0] idx,
                             logic [tvdds_pkg::SWEEP_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == tvdds_pkg::CFG_MODE) begin
            sweep_mode = val[0];
        end else if (idx == tvdds_pkg::CFG_SWEEP_STEP) begin
            sweep_step = val;
        end
        cfg_valid <= 1'b0;
    endtask

    // Request driver: holds a request until it is taken, then offers the next one.
    always @(posedge aclk) begin : pot_driver
        pot_set_t taken;
        pot_set_t next_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken = s_tdata[35:0];
                sample_expect_q.push_back(dds_next_sample(taken));
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_pots.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_pots.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= tvdds_pkg::S_DATA_W'(next_item);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sample checker and receiver back-pressure, including one long hold-off.
    always @(posedge aclk) begin : sample_checker
        bit [11:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sample_expect_q.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, got %0d",
                             $time, m_tdata[11:0]);
                    mismatch_count++;
                end else begin
                    want = sample_expect_q.pop_front();
                    if (m_tdata[11:0] !== want) begin
                        $display("%0t: sample mismatch, expected %0d, got %0d",
                                 $time, want, m_tdata[11:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[15:12] !== 4'd0) begin
                        $display("%0t: tdata padding mismatch, expected 0, got %0h",
                                 $time, m_tdata[15:12]);
                        mismatch_count++;
                    end
                end
                results_seen++;
                if (results_seen == HOLD_AT_RESULT) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        for (int i = 0; i < 1024; i++) begin
            wave_table[i] = sine_level(10'(i));
        end
        acc_phase  = '{32'd0, 32'd0, 32'd0};
        tune_word  = '{32'd15737418, 32'd25737418, 32'd35737418};
        sweep_mode = 1'b0;
        sweep_step = 16'd573;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Pot mode at reset settings: rescale end points and alternating bit patterns.
        queue_pots(12'd0, 12'd0, 12'd0);
        queue_pots(12'd4095, 12'd4095, 12'd4095);
        queue_pots(12'd0, 12'd0, 12'd0);
        queue_pots(12'd4095, 12'd0, 12'd2048);
        queue_pots(12'd1, 12'd4094, 12'd1);
        queue_pots(12'd2047, 12'd2048, 12'd4094);
        queue_pots(12'd4094, 12'd1, 12'd2047);
        queue_pots(12'd2048, 12'd2047, 12'd1);
        queue_pots(12'hAAA, 12'h555, 12'hAAA);
        queue_pots(12'h555, 12'hAAA, 12'h555);
        queue_pots(12'h800, 12'h001, 12'h400);
        queue_pots(12'h001, 12'h800, 12'h002);
        queue_pots(12'd3000, 12'd100, 12'd0);
        queue_pots(12'd0, 12'd4095, 12'd4095);
        queue_pots(12'd4095, 12'd4095, 12'd0);
        // Leaves voice b at its lowest word so the sweep below takes it through zero.
        queue_pots(12'd4095, 12'd0, 12'd4095);
        wait_drained();

        // Unmapped indexes are ignored; mode takes only its low bit.
        write_reg(CFG_UNMAPPED_LO, 16'hFFFF);
        write_reg(CFG_UNMAPPED_HI, 16'h1234);
        write_reg(tvdds_pkg::CFG_SWEEP_STEP, 16'hFFFF);
        write_reg(tvdds_pkg::CFG_MODE, 16'hFFFF);
        send_idle_pct = 32;
        recv_idle_pct = 48;
        queue_random(660);
        wait_drained();

        write_reg(tvdds_pkg::CFG_MODE, 16'hFFFE);
        write_reg(tvdds_pkg::CFG_SWEEP_STEP, 16'h0000);
        send_idle_pct = 48;
        recv_idle_pct = 32;
        queue_random(200);
        // The sender pauses here until every sample has come back.
        wait_drained();
        queue_random(200);
        wait_drained();

        // Sweep steps just below and at one unit, then a random one.
        write_reg(tvdds_pkg::CFG_MODE, 16'h0001);
        write_reg(tvdds_pkg::CFG_SWEEP_STEP, 16'd15);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(40);
        wait_drained();
        write_reg(tvdds_pkg::CFG_SWEEP_STEP, 16'd16);
        queue_random(60);
        wait_drained();
        write_reg(tvdds_pkg::CFG_SWEEP_STEP, 16'($urandom_range(65535)));
        queue_random(200);
        wait_drained();

        write_reg(tvdds_pkg::CFG_MODE, 16'h0000);
        queue_random(240);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
